// ----- rtl/load_frequency_governor_step_assert.svh -----
// Assertion macros shared by the RTL; empty when NO_ASSERTIONS is set.
`ifndef LOAD_FREQUENCY_GOVERNOR_STEP_ASSERT_SVH
`define LOAD_FREQUENCY_GOVERNOR_STEP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LFG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lfg: same-cycle check failed");
`define LFG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lfg: next-cycle check failed");
`else
`define LFG_ASSERT_NOW(lbl, ante, cons)
`define LFG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/lfg_pkg.sv -----
`default_nettype none

package lfg_pkg;

  localparam int unsigned FREQ_W    = 22;
  localparam int unsigned LOAD_W    = 7;
  localparam int unsigned CFG_IDX_W = 3;
  // operand a is a frequency plus the base delta, one bit wider
  localparam int unsigned OPA_W     = FREQ_W + 1;
  localparam int unsigned PROD_W    = OPA_W + LOAD_W;
  // dividend for the divide by 25 after the /4 or /8 shift
  localparam int unsigned DIV_W     = PROD_W - 2;
  localparam int unsigned RECIP_W   = 29;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned MULQ_W    = DIV_W + RECIP_W;
  localparam int unsigned QUOT_W    = MULQ_W - RECIP_SHIFT;
  localparam int unsigned SUM_W     = QUOT_W + 1;

  typedef logic [FREQ_W-1:0]    freq_t;
  typedef logic [LOAD_W-1:0]    load_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [QUOT_W-1:0]    quot_t;

  localparam cfg_idx_t REG_DOWN_THR  = 3'd0;
  localparam cfg_idx_t REG_UP_THR    = 3'd1;
  localparam cfg_idx_t REG_FAST_THR  = 3'd2;
  localparam cfg_idx_t REG_HS_TARGET = 3'd3;
  localparam cfg_idx_t REG_MIN_FREQ  = 3'd4;
  localparam cfg_idx_t REG_MAX_FREQ  = 3'd5;

  localparam load_t RST_DOWN_THR  = 7'd30;
  localparam load_t RST_UP_THR    = 7'd70;
  localparam load_t RST_FAST_THR  = 7'd95;
  localparam freq_t RST_HS_TARGET = 22'd1836000;
  localparam freq_t RST_MIN_FREQ  = 22'd0;
  localparam freq_t RST_MAX_FREQ  = 22'h3FFFFF;

  localparam freq_t FREQ_MAX    = 22'h3FFFFF;
  localparam freq_t BOOST_FLOOR = 22'd1428000;
  localparam logic [OPA_W-1:0] BASE_DELTA = 23'd10000;
  localparam load_t LOAD_CAP = 7'd110;
  // ceil(2^33 / 25): exact floor division for dividends below 2^28
  localparam logic [RECIP_W-1:0] RECIP_25 = 29'd343597384;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_NOTICE,
    BR_BOOST,
    BR_DOWN,
    BR_FAST,
    BR_HIGH
  } branch_e;

  typedef struct packed {
    load_t down_thr;
    load_t up_thr;
    load_t fast_thr;
    freq_t hs_target;
    freq_t min_freq;
    freq_t max_freq;
  } cfg_t;

  typedef struct packed {
    logic  req_valid;
    freq_t target;
    logic  high;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/load_frequency_governor_step.sv -----
// Load frequency governor step.
// Input channel (in_valid_i/in_ready_o) takes a load sample (opcode 0) or a
// frequency-change notice (opcode 1), one word per cycle while not stalled.
// Output channel (out_valid_o/out_ready_i) returns exactly one word per
// input word: request_valid, target_freq, relation_high. Non-request words
// carry zero target and relation.
// Throughput: one word per cycle unless out_ready_i stalls the output; the
// path is input register, operand multiply, divide by 25 (reciprocal
// multiply), then the rule stage that updates the kept request into the
// output register. The kept request only feeds that last stage, so
// back-to-back words see each other's update.
// Configuration: cfg_we_i writes register cfg_idx_i (0..5);
// write only while the pipeline is drained.
// Reset: registers go to their default values, the kept request to 0 and
// all pipeline stages empty.
// Stall: a held output word keeps its value; the stages behind it fill
// and in_ready_o drops once all four registers hold words.
`default_nettype none
`include "load_frequency_governor_step_assert.svh"

module load_frequency_governor_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  lfg_pkg::cfg_idx_t   cfg_idx_i,
  input  lfg_pkg::freq_t      cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  lfg_pkg::load_t      load_i,
  input  lfg_pkg::freq_t      current_freq_i,
  input  logic                boost_active_i,
  input  lfg_pkg::freq_t      new_freq_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                request_valid_o,
  output lfg_pkg::freq_t      target_freq_o,
  output logic                relation_high_o
);
  import lfg_pkg::*;

  cfg_t cfg_q;
  freq_t req_q, req_d;

  // stage 1: input register
  logic    v1_q;
  logic    op1_q, boost1_q;
  load_t   load1_q;
  freq_t   cur1_q, nf1_q;

  // stage 2: product
  logic              v2_q;
  branch_e           br2_q;
  logic [PROD_W-1:0] prod2_q;
  freq_t             cur2_q, nf2_q;
  logic              lt2_q;

  // stage 3: quotient
  logic    v3_q;
  branch_e br3_q;
  quot_t   quot3_q;
  freq_t   cur3_q, nf3_q;
  logic    lt3_q;

  // output register
  logic    outv_q;
  result_t res_q;
  result_t res_d;

  logic ld1, ld2, ld3, adv_o, fin_fire;

  assign adv_o    = !outv_q || out_ready_i;
  assign ld3      = !v3_q || adv_o;
  assign ld2      = !v2_q || ld3;
  assign ld1      = !v1_q || ld2;
  assign fin_fire = v3_q && adv_o;
  assign in_ready_o = ld1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.down_thr  <= RST_DOWN_THR;
      cfg_q.up_thr    <= RST_UP_THR;
      cfg_q.fast_thr  <= RST_FAST_THR;
      cfg_q.hs_target <= RST_HS_TARGET;
      cfg_q.min_freq  <= RST_MIN_FREQ;
      cfg_q.max_freq  <= RST_MAX_FREQ;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DOWN_THR:  cfg_q.down_thr  <= cfg_wdata_i[LOAD_W-1:0];
        REG_UP_THR:    cfg_q.up_thr    <= cfg_wdata_i[LOAD_W-1:0];
        REG_FAST_THR:  cfg_q.fast_thr  <= cfg_wdata_i[LOAD_W-1:0];
        REG_HS_TARGET: cfg_q.hs_target <= cfg_wdata_i;
        REG_MIN_FREQ:  cfg_q.min_freq  <= cfg_wdata_i;
        REG_MAX_FREQ:  cfg_q.max_freq  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // stage 1 -> 2: pick rule and multiply operands
  branch_e           br1;
  logic [OPA_W-1:0]  op_a;
  load_t             op_b;
  logic [PROD_W-1:0] prod_d;
  freq_t             span, cur_above_min, max_above_cur, hs_above_cur;
  load_t             load_room;

  assign span          = (cfg_q.max_freq > cfg_q.min_freq) ?
                         cfg_q.max_freq - cfg_q.min_freq : '0;
  assign cur_above_min = (cur1_q > cfg_q.min_freq) ? cur1_q - cfg_q.min_freq : '0;
  assign max_above_cur = (cfg_q.max_freq > cur1_q) ? cfg_q.max_freq - cur1_q : '0;
  assign hs_above_cur  = (cfg_q.hs_target > cur1_q) ? cfg_q.hs_target - cur1_q : '0;
  assign load_room     = (load1_q < LOAD_CAP) ? LOAD_CAP - load1_q : '0;

  always_comb begin
    priority if (op1_q) begin
      br1 = BR_NOTICE;
    end else if (boost1_q) begin
      br1 = BR_BOOST;
    end else if (load1_q < cfg_q.down_thr) begin
      br1 = (cur1_q != cfg_q.min_freq) ? BR_DOWN : BR_NONE;
    end else if (load1_q > cfg_q.fast_thr) begin
      br1 = BR_FAST;
    end else if (load1_q >= cfg_q.up_thr) begin
      br1 = BR_HIGH;
    end else begin
      br1 = BR_NONE;
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (br1)
      BR_BOOST: begin
        op_a = {1'b0, span};
        op_b = load1_q;
      end
      BR_DOWN: begin
        op_a = BASE_DELTA + {1'b0, cur_above_min};
        op_b = load_room;
      end
      BR_FAST: begin
        op_a = BASE_DELTA + {1'b0, max_above_cur};
        op_b = load1_q;
      end
      BR_HIGH: begin
        op_a = BASE_DELTA + {1'b0, hs_above_cur};
        op_b = load1_q;
      end
      BR_NONE, BR_NOTICE: begin
      end
      default: begin
      end
    endcase
  end

  assign prod_d = {{LOAD_W{1'b0}}, op_a} * {{OPA_W{1'b0}}, op_b};

  // stage 2 -> 3: /100 or /200 as a shift then a divide by 25
  logic [DIV_W-1:0]  dividend;
  logic [MULQ_W-1:0] recip_prod;

  assign dividend   = (br2_q == BR_BOOST) ? prod2_q[PROD_W-1:2]
                                          : {1'b0, prod2_q[PROD_W-1:3]};
  assign recip_prod = {{RECIP_W{1'b0}}, dividend} * {{DIV_W{1'b0}}, RECIP_25};

  // stage 3 -> output
  lfg_rule u_rule (
    .cfg_i       (cfg_q),
    .br_i        (br3_q),
    .quot_i      (quot3_q),
    .cur_i       (cur3_q),
    .nf_i        (nf3_q),
    .cur_lt_hs_i (lt3_q),
    .req_i       (req_q),
    .req_o       (req_d),
    .res_o       (res_d)
  );

  // valid bits and kept request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      outv_q <= 1'b0;
      req_q  <= '0;
    end else begin
      if (ld1) begin
        v1_q <= in_valid_i;
      end
      if (ld2) begin
        v2_q <= v1_q;
      end
      if (ld3) begin
        v3_q <= v2_q;
      end
      if (adv_o) begin
        outv_q <= v3_q;
      end
      if (fin_fire) begin
        req_q <= req_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      op1_q    <= opcode_i;
      load1_q  <= load_i;
      cur1_q   <= current_freq_i;
      boost1_q <= boost_active_i;
      nf1_q    <= new_freq_i;
    end
    if (ld2 && v1_q) begin
      br2_q   <= br1;
      prod2_q <= prod_d;
      cur2_q  <= cur1_q;
      nf2_q   <= nf1_q;
      lt2_q   <= cur1_q < cfg_q.hs_target;
    end
    if (ld3 && v2_q) begin
      br3_q   <= br2_q;
      quot3_q <= recip_prod[MULQ_W-1:RECIP_SHIFT];
      cur3_q  <= cur2_q;
      nf3_q   <= nf2_q;
      lt3_q   <= lt2_q;
    end
    if (fin_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = outv_q;
  assign request_valid_o = res_q.req_valid;
  assign target_freq_o   = res_q.target;
  assign relation_high_o = res_q.high;

  // kept request moves only when a word leaves the rule stage
  `LFG_ASSERT_NEXT(a_req_hold, !fin_fire, $stable(req_q))
  // a shown request is the kept request until the next word replaces it
  `LFG_ASSERT_NOW(a_req_match, outv_q && res_q.req_valid, res_q.target == req_q)
  // words without a request carry zero fields
  `LFG_ASSERT_NOW(a_noreq_zero, outv_q && !res_q.req_valid,
                  res_q.target == '0 && !res_q.high)

endmodule

`default_nettype wire

// ----- rtl/lfg_rule.sv -----
`default_nettype none

// Final rule stage: sets the kept request from the scaled step or a notice.
module lfg_rule (
  input  lfg_pkg::cfg_t    cfg_i,
  input  lfg_pkg::branch_e br_i,
  input  lfg_pkg::quot_t   quot_i,
  input  lfg_pkg::freq_t   cur_i,
  input  lfg_pkg::freq_t   nf_i,
  input  logic             cur_lt_hs_i,
  input  lfg_pkg::freq_t   req_i,
  output lfg_pkg::freq_t   req_o,
  output lfg_pkg::result_t res_o
);
  import lfg_pkg::*;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] boost_t;
  freq_t            diff;
  freq_t            hs_step;

  assign sum     = {3'b0, req_i} + {1'b0, quot_i};
  assign boost_t = {1'b0, quot_i} + {3'b0, cfg_i.min_freq};
  assign diff    = req_i - quot_i[FREQ_W-1:0];

  always_comb begin
    req_o   = req_i;
    res_o   = '0;
    hs_step = cfg_i.hs_target;
    unique case (br_i)
      BR_NOTICE: begin
        if (req_i > cfg_i.max_freq || req_i < cfg_i.min_freq) begin
          req_o = nf_i;
        end
      end
      BR_BOOST: begin
        if (boost_t < {3'b0, BOOST_FLOOR}) begin
          req_o = BOOST_FLOOR;
        end else if (boost_t > {3'b0, FREQ_MAX}) begin
          req_o = FREQ_MAX;
        end else begin
          req_o = boost_t[FREQ_W-1:0];
        end
        res_o.req_valid = 1'b1;
        res_o.high      = req_o > cur_i;
      end
      BR_DOWN: begin
        if ({2'b0, req_i} > quot_i) begin
          req_o = (diff < cfg_i.min_freq) ? cfg_i.min_freq : diff;
        end else begin
          req_o = cfg_i.min_freq;
        end
        res_o.req_valid = 1'b1;
      end
      BR_FAST: begin
        if (req_i != cfg_i.max_freq) begin
          req_o = (sum > {3'b0, cfg_i.max_freq}) ? cfg_i.max_freq : sum[FREQ_W-1:0];
          res_o.req_valid = 1'b1;
          res_o.high      = 1'b1;
        end
      end
      BR_HIGH: begin
        if (req_i != cfg_i.hs_target) begin
          if (cur_lt_hs_i && sum <= {3'b0, cfg_i.hs_target}) begin
            hs_step = sum[FREQ_W-1:0];
          end
          req_o = (hs_step > cfg_i.max_freq) ? cfg_i.max_freq : hs_step;
          res_o.req_valid = 1'b1;
          res_o.high      = 1'b1;
        end
      end
      BR_NONE: begin
      end
      default: begin
      end
    endcase
    if (res_o.req_valid) begin
      res_o.target = req_o;
    end
  end

endmodule

`default_nettype wire

// ----- dv/load_frequency_governor_step_test.sv -----
module load_frequency_governor_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lfg_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_NOTICE = 1'b1;

  localparam logic [63:0] BASE_KHZ    = 64'd10000;
  localparam logic [63:0] STEP_DIV    = 64'd200;
  localparam logic [63:0] PCT_DIV     = 64'd100;
  localparam logic [63:0] LOAD_LIMIT  = 64'd110;
  localparam logic [63:0] BOOST_KHZ   = 64'd1428000;
  localparam logic [63:0] FREQ_CEIL   = 64'h3FFFFF;
  localparam int          PHASE_WORDS = 175;
  localparam int          PHASES      = 10;

  typedef struct packed {
    logic  opcode;
    load_t load;
    freq_t cur;
    logic  boost;
    freq_t new_freq;
  } gov_word_t;

  typedef struct packed {
    gov_word_t w;
    logic      literal_exp;
    result_t   res;
  } table_row_t;

  logic     clk_i;
  logic     rst_ni         = 1'b0;
  logic     cfg_we_i       = 1'b0;
  cfg_idx_t cfg_idx_i      = REG_DOWN_THR;
  freq_t    cfg_wdata_i    = '0;
  logic     in_valid_i     = 1'b0;
  logic     in_ready_o;
  logic     opcode_i       = OP_SAMPLE;
  load_t    load_i         = '0;
  freq_t    current_freq_i = '0;
  logic     boost_active_i = 1'b0;
  freq_t    new_freq_i     = '0;
  logic     out_valid_o;
  logic     out_ready_i    = 1'b0;
  logic     request_valid_o;
  freq_t    target_freq_o;
  logic     relation_high_o;

  // predictor state and its copy of the registers
  freq_t      kept_request = '0;
  cfg_t       gov_cfg      = {RST_DOWN_THR, RST_UP_THR, RST_FAST_THR,
                              RST_HS_TARGET, RST_MIN_FREQ, RST_MAX_FREQ};
  result_t    requests_due[$];
  result_t    due;
  table_row_t stim_table[$];
  int         error_count  = 0;
  int         burst_left   = 0;
  logic [1:0] stall_mode   = 2'd0;
  logic [7:0] stall_cnt    = '0;

  load_frequency_governor_step dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [63:0] sat_diff(logic [63:0] a, logic [63:0] b);
    return (a > b) ? a - b : 64'd0;
  endfunction

  function automatic logic [63:0] clamp22(logic [63:0] v);
    return (v > FREQ_CEIL) ? FREQ_CEIL : v;
  endfunction

  // one governor step: updates kept_request, returns the output word
  function automatic result_t govern(gov_word_t w);
    logic [63:0] req, mn, mx, hs, cur, ld, t, red;
    result_t r;
    req = 64'(kept_request);
    mn  = 64'(gov_cfg.min_freq);
    mx  = 64'(gov_cfg.max_freq);
    hs  = 64'(gov_cfg.hs_target);
    cur = 64'(w.cur);
    ld  = 64'(w.load);
    r   = '0;
    if (w.opcode == OP_NOTICE) begin
      if (req > mx || req < mn) req = 64'(w.new_freq);
    end else if (w.boost) begin
      t = sat_diff(mx, mn) * ld / PCT_DIV + mn;
      req = clamp22((t > BOOST_KHZ) ? t : BOOST_KHZ);
      r.req_valid = 1'b1;
      r.high = (req > cur);
    end else if (ld < 64'(gov_cfg.down_thr)) begin
      if (cur != mn) begin
        red = (BASE_KHZ + sat_diff(cur, mn)) * sat_diff(LOAD_LIMIT, ld) / STEP_DIV;
        req = (req > red) ? req - red : mn;
        if (req < mn) req = mn;
        r.req_valid = 1'b1;
      end
    end else if (ld > 64'(gov_cfg.fast_thr)) begin
      if (req != mx) begin
        req = req + (BASE_KHZ + sat_diff(mx, cur)) * ld / STEP_DIV;
        if (req > mx) req = mx;
        r.req_valid = 1'b1;
        r.high = 1'b1;
      end
    end else if (ld >= 64'(gov_cfg.up_thr)) begin
      if (req != hs) begin
        if (cur < hs) begin
          req = req + (BASE_KHZ + hs - cur) * ld / STEP_DIV;
          if (req > hs) req = hs;
        end else begin
          req = hs;
        end
        if (req > mx) req = mx;
        r.req_valid = 1'b1;
        r.high = 1'b1;
      end
    end
    kept_request = freq_t'(clamp22(req));
    if (r.req_valid) r.target = kept_request;
    return r;
  endfunction

  function automatic gov_word_t random_word();
    gov_word_t w;
    w.opcode = ($urandom_range(0, 9) == 0) ? OP_NOTICE : OP_SAMPLE;
    w.boost  = ($urandom_range(0, 7) == 0);
    // aim the load at each rule band, edges included
    case ($urandom_range(0, 5))
      0:       w.load = load_t'($urandom_range(0, gov_cfg.down_thr));
      1:       w.load = load_t'($urandom_range(gov_cfg.down_thr, gov_cfg.up_thr));
      2:       w.load = load_t'($urandom_range(gov_cfg.up_thr, gov_cfg.fast_thr));
      3:       w.load = load_t'($urandom_range(gov_cfg.fast_thr, 100));
      4:       w.load = load_t'($urandom_range(0, 127));
      default: w.load = load_t'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 5))
      0:       w.cur = gov_cfg.min_freq;
      1:       w.cur = gov_cfg.max_freq;
      2:       w.cur = gov_cfg.hs_target;
      3:       w.cur = freq_t'($urandom_range(0, FREQ_MAX));
      default: w.cur = freq_t'($urandom_range(gov_cfg.min_freq, gov_cfg.max_freq));
    endcase
    w.new_freq = $urandom_range(0, 1) ? freq_t'($urandom_range(0, FREQ_MAX))
                                      : freq_t'($urandom_range(gov_cfg.min_freq,
                                                               gov_cfg.max_freq));
    return w;
  endfunction

  task automatic add_row(logic op, int ld, freq_t cur, logic boost, freq_t nf,
                         logic literal_exp, logic rv, freq_t tgt, logic hi);
    table_row_t row;
    row.w.opcode    = op;
    row.w.load      = load_t'(ld);
    row.w.cur       = cur;
    row.w.boost     = boost;
    row.w.new_freq  = nf;
    row.literal_exp = literal_exp;
    row.res         = {rv, tgt, hi};
    stim_table.push_back(row);
  endtask

  // holds the word until taken, then decides on a gap before the next one
  task automatic send_word(gov_word_t w, logic literal_exp, result_t literal_res);
    result_t r;
    opcode_i       <= w.opcode;
    load_i         <= w.load;
    current_freq_i <= w.cur;
    boost_active_i <= w.boost;
    new_freq_i     <= w.new_freq;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r = govern(w);
    requests_due.push_back(literal_exp ? literal_res : r);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, freq_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_DOWN_THR:  gov_cfg.down_thr  = load_t'(val);
      REG_UP_THR:    gov_cfg.up_thr    = load_t'(val);
      REG_FAST_THR:  gov_cfg.fast_thr  = load_t'(val);
      REG_HS_TARGET: gov_cfg.hs_target = val;
      REG_MIN_FREQ:  gov_cfg.min_freq  = val;
      REG_MAX_FREQ:  gov_cfg.max_freq  = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // registers change only with nothing in flight
  task automatic apply_setting(cfg_t c);
    in_valid_i <= 1'b0;
    while (requests_due.size() != 0) @(posedge clk_i);
    write_reg(REG_DOWN_THR, freq_t'(c.down_thr));
    write_reg(REG_UP_THR, freq_t'(c.up_thr));
    write_reg(REG_FAST_THR, freq_t'(c.fast_thr));
    write_reg(REG_HS_TARGET, c.hs_target);
    write_reg(REG_MIN_FREQ, c.min_freq);
    write_reg(REG_MAX_FREQ, c.max_freq);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 8'd1;
    if (stall_cnt[5:0] == 6'h3F) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= stall_cnt[2];
      default: out_ready_i <= (stall_cnt[3:0] == 4'd0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (requests_due.size() == 0) begin
        $display("%0t: unexpected word: request_valid=%0b target_freq=%0d relation_high=%0b",
                 $time, request_valid_o, target_freq_o, relation_high_o);
        error_count++;
      end else begin
        due = requests_due.pop_front();
        if (request_valid_o !== due.req_valid) begin
          $display("%0t: request_valid expected %0b actual %0b",
                   $time, due.req_valid, request_valid_o);
          error_count++;
        end
        if (target_freq_o !== due.target) begin
          $display("%0t: target_freq expected %0d actual %0d",
                   $time, due.target, target_freq_o);
          error_count++;
        end
        if (relation_high_o !== due.high) begin
          $display("%0t: relation_high expected %0b actual %0b",
                   $time, due.high, relation_high_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    cfg_t setting;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: thresholds 30/70/95, full range, request 0
    add_row(OP_NOTICE, 0, 0, 1'b0, FREQ_MAX, 1'b1, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 50, 22'd1000000, 1'b0, '0, 1'b1, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 0, '0, 1'b1, '0, 1'b1, 1'b1, BOOST_FLOOR, 1'b1);
    add_row(OP_SAMPLE, 100, FREQ_MAX, 1'b1, '0, 1'b1, 1'b1, FREQ_MAX, 1'b0);
    // boost overflow saturates
    add_row(OP_SAMPLE, 127, '0, 1'b1, '0, 1'b1, 1'b1, FREQ_MAX, 1'b1);
    // request already at max, current at min: both no-ops
    add_row(OP_SAMPLE, 100, '0, 1'b0, '0, 1'b1, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 0, '0, 1'b0, '0, 1'b1, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 0, FREQ_MAX, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 96, 22'd2000000, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 29, 22'd3000000, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 70, '0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 94, FREQ_MAX, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 80, 22'd500000, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 95, 22'd1000000, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 127, '0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 30, 22'd1000000, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    // walk the request down until it pins at min
    add_row(OP_SAMPLE, 0, FREQ_MAX, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 0, FREQ_MAX, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 0, FREQ_MAX, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_NOTICE, 127, FREQ_MAX, 1'b1, 22'd12345, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 69, FREQ_MAX, 1'b1, '0, 1'b0, 1'b0, '0, 1'b0);
    add_row(OP_SAMPLE, 1, 22'd1, 1'b0, FREQ_MAX, 1'b0, 1'b0, '0, 1'b0);
    foreach (stim_table[i]) send_word(stim_table[i].w, stim_table[i].literal_exp,
                                      stim_table[i].res);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        // thresholds at the top of their width: step-down factor hits zero
        0: setting = {7'd127, 7'd127, 7'd127, FREQ_MAX, 22'd0, FREQ_MAX};
        1: setting = {7'd0, 7'd0, 7'd0, 22'd0, 22'd0, 22'd0};
        2: setting = {7'd20, 7'd60, 7'd90, 22'd800000, 22'd100000, 22'd900000};
        // min above max, thresholds out of order
        3: setting = {7'd80, 7'd20, 7'd50, 22'd2000000, 22'd3000000, 22'd1000000};
        4: setting = {7'd30, 7'd70, 7'd95, 22'd1500000, 22'd1200000, 22'd1200000};
        5: setting = {7'd10, 7'd50, 7'd100, FREQ_MAX, FREQ_MAX, FREQ_MAX};
        default: begin
          setting.down_thr  = load_t'($urandom_range(0, 60));
          setting.up_thr    = load_t'($urandom_range(setting.down_thr, 100));
          setting.fast_thr  = load_t'($urandom_range(setting.up_thr, 100));
          setting.min_freq  = freq_t'($urandom_range(0, 2000000));
          setting.max_freq  = freq_t'($urandom_range(setting.min_freq, FREQ_MAX));
          setting.hs_target = freq_t'($urandom_range(setting.min_freq, setting.max_freq));
        end
      endcase
      apply_setting(setting);
      repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (requests_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- load_frequency_governor_step.f -----
+incdir+rtl
rtl/lfg_pkg.sv
rtl/lfg_rule.sv
rtl/load_frequency_governor_step.sv
dv/load_frequency_governor_step_test.sv
